// ===== rtl/pfdp_pkg.sv =====
// Package for the PWM frequency/duty programmer: payload structs, opcodes,
// channel modes, controller states and divider handshake types.
// No dependencies; every other file imports this one.
package pfdp_pkg;

	// Field widths fixed by the command and result formats
	localparam int unsigned OPCODE_W   = 3;
	localparam int unsigned CHANNEL_W  = 8;
	localparam int unsigned FREQ_W     = 32;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned REG16_W    = 16;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned NUM_GROUPS = 2;
	localparam int unsigned NUM_CHANS  = 8;
	localparam int unsigned CHIDX_W    = $clog2(NUM_CHANS);

	// Bit-serial divider
	localparam int unsigned DIV_W     = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
	localparam int unsigned PSC_W     = 17;

	// APB register map
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned PADDR_W    = 3;
	localparam logic [PADDR_W-3:0] REG_CLOCK_HZ = '0;

	// Constants of the timer arithmetic
	localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = 32'd24000000;
	localparam logic [DIV_W-1:0]  PSC_LIMIT      = 32'd65535;
	localparam logic [DIV_W-1:0]  DUTY_SCALE     = 32'd10000;
	localparam logic [DUTY_W-1:0] DUTY_FULL      = 16'd10000;
	localparam logic [CHANNEL_W-1:0] CHAN_LAST    = 8'd8;
	localparam logic [CHANNEL_W-1:0] GROUP_A_LAST = 8'd4;

	// Command opcodes
	typedef enum logic [OPCODE_W-1:0] {
		OP_SET_FREQ    = 3'd0,
		OP_SET_DUTY    = 3'd1,
		OP_PULSE_START = 3'd2,
		OP_WAVE_START  = 3'd3,
		OP_START       = 3'd4,
		OP_STOP        = 3'd5
	} op_t;

	// Channel output modes
	typedef enum logic [MODE_W-1:0] {
		MODE_UNSET = 2'd0,
		MODE_LOW   = 2'd1,
		MODE_HIGH  = 2'd2,
		MODE_PWM   = 2'd3
	} mode_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RATIO_GO,
		ST_RATIO_WAIT,
		ST_PSC_GO,
		ST_PSC_WAIT,
		ST_PER_GO,
		ST_PER_WAIT,
		ST_MUL,
		ST_CMP_GO,
		ST_CMP_WAIT,
		ST_APPLY,
		ST_REPORT
	} state_t;

	// Command payload
	typedef struct packed {
		logic [OPCODE_W-1:0]  opcode;
		logic [CHANNEL_W-1:0] channel;
		logic [FREQ_W-1:0]    frequency_hz;
		logic [DUTY_W-1:0]    duty;
		logic [COUNT_W-1:0]   pulse_count;
	} cmd_t;

	// Result payload
	typedef struct packed {
		logic                group_sel;
		logic [REG16_W-1:0]  prescaler_value;
		logic [REG16_W-1:0]  period_value;
		logic [MODE_W-1:0]   channel_mode;
		logic [REG16_W-1:0]  compare_value;
		logic                running;
		logic                output_enable;
		logic                one_pulse;
		logic [COUNT_W-1:0]  repeat_count;
		logic                changed;
	} res_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/pfdp_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one cmd_t.
// Depends on pfdp_pkg.
interface pfdp_cmd_if;
	import pfdp_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pfdp_res_if.sv =====
// Result channel: valid/ready handshake carrying one res_t.
// Depends on pfdp_pkg.
interface pfdp_res_if;
	import pfdp_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pfdp_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on pfdp_pkg; the divisor must be nonzero.
module pfdp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pfdp_pkg::div_req_t req,
	output pfdp_pkg::div_rsp_t rsp
);
	import pfdp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 take;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = (trial >= {1'b0, dvs_q});

	// Sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/pwm_frequency_duty_programmer_core.sv =====
// Channel   Kind        Payload
// cmd       sink        opcode, channel, frequency_hz, duty, pulse_count
// res       source      group_sel .. changed, one result per command
// apb       APB slave   clock_hz at byte address 0
//
// One command at a time. Plain commands pass from decode straight to apply
// and report; set_duty and wave_start in PWM range add a multiply and one
// division; set_freq adds one division, or three when the ratio needs a
// prescaler. Divisions run on the shared 32-bit bit-serial divider.
// A finished result waits in the output register while the next command is
// taken; the following result holds in the report state until that register
// is free. Reset clears all timer registers and loads clock_hz with 24000000.
//
// Timer register model top level; depends on pfdp_pkg, pfdp_cmd_if,
// pfdp_res_if and pfdp_div.
module pwm_frequency_duty_programmer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	pfdp_cmd_if.sink                          cmd,
	pfdp_res_if.source                        res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pfdp_pkg::PADDR_W-1:0]      paddr,
	input  logic [pfdp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pfdp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import pfdp_pkg::*;

	// Configuration
	logic [FREQ_W-1:0] clock_hz_q;

	// Control
	state_t state_q, state_d;
	logic   changed_q;
	logic   res_valid_q;
	res_t   res_data_q;
	res_t   res_next;
	logic   slot_free;
	logic   res_load;

	// Command and datapath
	cmd_t             cmd_q;
	logic [DIV_W-1:0] ratio_q;
	logic [PSC_W-1:0] psc_q;
	logic [DIV_W-1:0] work_q;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// Timer registers
	logic [REG16_W-1:0] grp_psc_q   [NUM_GROUPS];
	logic [REG16_W-1:0] grp_per_q   [NUM_GROUPS];
	logic               grp_run_q   [NUM_GROUPS];
	logic               grp_oe_q    [NUM_GROUPS];
	logic               grp_opm_q   [NUM_GROUPS];
	logic [COUNT_W-1:0] grp_rep_q   [NUM_GROUPS];
	logic [MODE_W-1:0]  chan_mode_q [NUM_CHANS];
	logic [REG16_W-1:0] chan_cmp_q  [NUM_CHANS];

	// Decoded addressing
	logic               grp;
	logic [CHIDX_W-1:0] chi;
	logic               ch_valid;
	logic               ch_own;
	logic               duty_pwm;
	logic [MODE_W-1:0]  duty_mode;
	logic [REG16_W-1:0] duty_cmp;
	logic [DIV_W-1:0]   per_dec;
	logic [2*REG16_W-1:0] duty_prod;
	logic               apply_changed;

	assign grp      = (cmd_q.channel > GROUP_A_LAST);
	assign chi      = cmd_q.channel[CHIDX_W-1:0] - 1'b1;
	assign ch_valid = (cmd_q.channel <= CHAN_LAST);
	assign ch_own   = ch_valid && (cmd_q.channel != '0);
	assign duty_pwm = (cmd_q.duty != '0) && (cmd_q.duty < DUTY_FULL);

	// Full-width period times duty
	assign duty_prod = grp_per_q[grp] * cmd_q.duty;

	// Mode and compare from the requested duty
	always_comb begin
		if (cmd_q.duty == '0) begin
			duty_mode = MODE_LOW;
			duty_cmp  = '0;
		end else if (cmd_q.duty >= DUTY_FULL) begin
			duty_mode = MODE_HIGH;
			duty_cmp  = '0;
		end else begin
			duty_mode = MODE_PWM;
			duty_cmp  = work_q[REG16_W-1:0];
		end
	end

	// Auto-reload value is one less than the period count
	assign per_dec = (work_q != '0) ? (work_q - 1'b1) : '0;

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_CLOCK_HZ) ? clock_hz_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[PADDR_W-1:2] == REG_CLOCK_HZ)) begin
			clock_hz_q <= pwdata;
		end
	end

	// Shared divider
	pfdp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (!ch_valid) begin
					state_d = ST_REPORT;
				end else if ((cmd_q.opcode == OP_SET_FREQ) && (cmd_q.frequency_hz != '0)) begin
					state_d = ST_RATIO_GO;
				end else if ((cmd_q.opcode inside {OP_SET_DUTY, OP_WAVE_START})
						&& ch_own && duty_pwm) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_RATIO_GO:   state_d = ST_RATIO_WAIT;
			ST_RATIO_WAIT: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.quotient >= PSC_LIMIT) ? ST_PSC_GO : ST_APPLY;
				end
			end
			ST_PSC_GO:     state_d = ST_PSC_WAIT;
			ST_PSC_WAIT: begin
				if (div_rsp.done) state_d = ST_PER_GO;
			end
			ST_PER_GO:     state_d = ST_PER_WAIT;
			ST_PER_WAIT: begin
				if (div_rsp.done) state_d = ST_APPLY;
			end
			ST_MUL:        state_d = ST_CMP_GO;
			ST_CMP_GO:     state_d = ST_CMP_WAIT;
			ST_CMP_WAIT: begin
				if (div_rsp.done) state_d = ST_APPLY;
			end
			ST_APPLY:      state_d = ST_REPORT;
			ST_REPORT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// State-driven outputs: handshake and divider requests
	always_comb begin
		cmd.ready       = 1'b0;
		res_load        = 1'b0;
		div_req.start   = 1'b0;
		div_req.dividend = work_q;
		div_req.divisor  = DUTY_SCALE;
		case (state_q)
			ST_IDLE:   cmd.ready = 1'b1;
			ST_RATIO_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = clock_hz_q;
				div_req.divisor  = cmd_q.frequency_hz;
			end
			ST_PSC_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = ratio_q;
				div_req.divisor  = PSC_LIMIT;
			end
			ST_PER_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = ratio_q;
				div_req.divisor  = DIV_W'(psc_q) + 1'b1;
			end
			ST_CMP_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = work_q;
				div_req.divisor  = DUTY_SCALE;
			end
			ST_REPORT: res_load = slot_free;
			default: ;
		endcase
	end

	// Whether the command writes any register
	always_comb begin
		case (cmd_q.opcode)
			OP_SET_FREQ:    apply_changed = (cmd_q.frequency_hz != '0);
			OP_SET_DUTY:    apply_changed = ch_own;
			OP_PULSE_START: apply_changed = (cmd_q.pulse_count != '0);
			OP_WAVE_START,
			OP_START,
			OP_STOP:        apply_changed = 1'b1;
			default:        apply_changed = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			changed_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE) changed_q <= 1'b0;
			else if (state_q == ST_APPLY) changed_q <= apply_changed;
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	// Command capture and division results
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) cmd_q <= cmd.data;
		case (state_q)
			ST_RATIO_WAIT: begin
				if (div_rsp.done) begin
					ratio_q <= div_rsp.quotient;
					psc_q   <= '0;
					work_q  <= div_rsp.quotient;
				end
			end
			ST_PSC_WAIT: begin
				if (div_rsp.done) psc_q <= div_rsp.quotient[PSC_W-1:0];
			end
			ST_PER_WAIT,
			ST_CMP_WAIT: begin
				if (div_rsp.done) work_q <= div_rsp.quotient;
			end
			ST_MUL: work_q <= duty_prod;
			default: ;
		endcase
	end

	// Timer register updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_psc_q[g] <= '0;
				grp_per_q[g] <= '0;
				grp_run_q[g] <= 1'b0;
				grp_oe_q[g]  <= 1'b0;
				grp_opm_q[g] <= 1'b0;
				grp_rep_q[g] <= '0;
			end
			for (int c = 0; c < NUM_CHANS; c++) begin
				chan_mode_q[c] <= MODE_UNSET;
				chan_cmp_q[c]  <= '0;
			end
		end else if (state_q == ST_APPLY) begin
			case (cmd_q.opcode)
				OP_SET_FREQ: begin
					if (cmd_q.frequency_hz != '0) begin
						grp_psc_q[grp] <= psc_q[REG16_W-1:0];
						grp_per_q[grp] <= per_dec[REG16_W-1:0];
					end
				end
				OP_SET_DUTY: begin
					if (ch_own) begin
						chan_mode_q[chi] <= duty_mode;
						chan_cmp_q[chi]  <= duty_cmp;
					end
				end
				OP_PULSE_START: begin
					if (cmd_q.pulse_count != '0) begin
						if (ch_own) begin
							chan_mode_q[chi] <= MODE_PWM;
							chan_cmp_q[chi]  <= grp_per_q[grp] >> 1;
						end
						grp_opm_q[grp] <= 1'b1;
						grp_rep_q[grp] <= cmd_q.pulse_count - 1'b1;
						grp_run_q[grp] <= 1'b1;
						grp_oe_q[grp]  <= 1'b1;
					end
				end
				OP_WAVE_START: begin
					if (ch_own) begin
						chan_mode_q[chi] <= duty_mode;
						chan_cmp_q[chi]  <= duty_cmp;
					end
					grp_opm_q[grp] <= 1'b0;
					grp_run_q[grp] <= 1'b1;
					grp_oe_q[grp]  <= 1'b1;
				end
				OP_START: begin
					grp_run_q[grp] <= 1'b1;
					grp_oe_q[grp]  <= 1'b1;
				end
				OP_STOP: begin
					grp_run_q[grp] <= 1'b0;
					grp_oe_q[grp]  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Assemble the result from the updated registers
	always_comb begin
		res_next = '0;
		if (ch_valid) begin
			res_next.group_sel       = grp;
			res_next.prescaler_value = grp_psc_q[grp];
			res_next.period_value    = grp_per_q[grp];
			res_next.channel_mode    = ch_own ? chan_mode_q[chi] : MODE_UNSET;
			res_next.compare_value   = ch_own ? chan_cmp_q[chi] : '0;
			res_next.running         = grp_run_q[grp];
			res_next.output_enable   = grp_oe_q[grp];
			res_next.one_pulse       = grp_opm_q[grp];
			res_next.repeat_count    = grp_rep_q[grp];
			res_next.changed         = changed_q;
		end
	end

	// Output register
	assign slot_free = !res_valid_q || res.ready;

	always_ff @(posedge clk) begin
		if (res_load) res_data_q <= res_next;
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

`ifndef NO_ASSERTIONS
	// Only one command in flight: a transfer closes the input until the result is built
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while another is in progress");

	// The divider is never restarted mid-division
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A result for an out-of-range channel is all zero
	a_bad_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && !ch_valid |=> res_data_q == '0)
		else $error("nonzero result for an ignored channel");

	// A result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !res_valid_q || res.ready)
		else $error("pending result overwritten");
`endif

endmodule
